@@ rtl/fst_pkg.sv @@
// fst_pkg: shared types and constants for the format specifier tokenizer
// no dependencies; imported by the result channel interface and the top level

package fst_pkg;

    localparam int unsigned NUM_W = 31;
    localparam logic [NUM_W-1:0] NUM_MAX = 31'h7FFF_FFFF;

    // parser position inside a specifier
    typedef enum logic [2:0] {
        PH_OUT   = 3'd0,
        PH_PCT   = 3'd1,
        PH_ARGN  = 3'd2,
        PH_KEY   = 3'd3,
        PH_FLAGS = 3'd4,
        PH_WIDTH = 3'd5,
        PH_DOT   = 3'd6,
        PH_PREC  = 3'd7
    } phase_t;

    // result kinds
    localparam logic [2:0] K_LIT  = 3'd0;
    localparam logic [2:0] K_KEY  = 3'd1;
    localparam logic [2:0] K_SPEC = 3'd2;
    localparam logic [2:0] K_ERR  = 3'd3;
    localparam logic [2:0] K_END  = 3'd4;
    localparam logic [2:0] K_NONE = 3'd7;

    // error codes
    localparam logic [2:0] E_UNTERM = 3'd0;
    localparam logic [2:0] E_RANGE  = 3'd1;
    localparam logic [2:0] E_ZERO   = 3'd2;
    localparam logic [2:0] E_PAREN  = 3'd3;
    localparam logic [2:0] E_NOPREC = 3'd4;
    localparam logic [2:0] E_TYPE   = 3'd5;

    // type codes
    localparam logic [1:0] T_STR   = 2'd0;
    localparam logic [1:0] T_IDENT = 2'd1;
    localparam logic [1:0] T_LIT   = 2'd2;

    // special bytes
    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_S      = 8'h73;
    localparam logic [7:0] CH_I      = 8'h49;
    localparam logic [7:0] CH_L      = 8'h4C;

    // one result item
    typedef struct packed {
        logic [2:0]       kind;
        logic [7:0]       char_value;
        logic [NUM_W-1:0] arg_number;
        logic             has_key;
        logic             left_align;
        logic [NUM_W-1:0] field_width;
        logic [NUM_W-1:0] precision_value;
        logic [1:0]       type_code;
        logic [2:0]       error_code;
        logic             string_end;
    } result_t;

endpackage

@@ rtl/fst_if.sv @@
// fst_if: valid/ready channel interfaces for format bytes and result items
// depends on fst_pkg for the number width

interface fst_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] format_byte;
    logic       last_byte;

    modport source (output valid, output format_byte, output last_byte, input ready);
    modport sink   (input valid, input format_byte, input last_byte, output ready);
endinterface

interface fst_result_if import fst_pkg::*;;
    logic             valid;
    logic             ready;
    logic [2:0]       kind;
    logic [7:0]       char_value;
    logic [NUM_W-1:0] arg_number;
    logic             has_key;
    logic             left_align;
    logic [NUM_W-1:0] field_width;
    logic [NUM_W-1:0] precision_value;
    logic [1:0]       type_code;
    logic [2:0]       error_code;
    logic             string_end;

    modport source (
        output valid, output kind, output char_value, output arg_number,
        output has_key, output left_align, output field_width,
        output precision_value, output type_code, output error_code,
        output string_end, input ready
    );
    modport sink (
        input valid, input kind, input char_value, input arg_number,
        input has_key, input left_align, input field_width,
        input precision_value, input type_code, input error_code,
        input string_end, output ready
    );
endinterface

@@ rtl/format_specifier_tokenizer_top.sv @@
// format_specifier_tokenizer_top: byte-serial format string tokenizer
// depends on fst_pkg and the channel interfaces in fst_if.sv
//
// usage
//   fmt carries one byte of the format string per item, last_byte marks the
//   final byte of a string. res carries at most one result item per byte:
//   literal bytes and %% as literals, key bytes one by one, a spec record at
//   the type byte, an error, or an end marker on the last byte after an error
// pipeline and throughput
//   a byte accepted into the input register has its result loaded into the
//   result register once that register is free, and shows on res.valid from
//   then on. one byte per cycle is sustained while res.ready stays high; the
//   per-byte work is a phase update plus one multiply-by-ten accumulate with
//   a range check, all combinational
//   bytes that cause no result (a '%', a digit, a flag) take a slot too
// reset
//   rst_n clears both registers' valid flags and the parser state; parsing
//   starts outside any specifier. the state also returns to reset after
//   every last byte, so each string is parsed on its own
// stall
//   while res.ready is low the result register holds its item and the input
//   register can still take one more byte; then fmt.ready drops

module format_specifier_tokenizer_top
    import fst_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    fst_byte_if.sink            fmt,
    fst_result_if.source        res
);

    // input register
    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_last_reg;

    // result register
    logic       res_valid_reg;
    result_t    res_reg;
    result_t    res_next;
    logic       res_valid_next;

    // parser state
    phase_t           phase_reg, phase_next;
    logic [NUM_W-1:0] acc_reg, acc_next;
    logic [NUM_W-1:0] arg_reg, arg_next;
    logic [NUM_W-1:0] width_reg, width_next;
    logic [NUM_W-1:0] prec_reg, prec_next;
    logic             left_reg, left_next;
    logic             key_reg, key_next;
    logic [NUM_W-1:0] last_arg_reg, last_arg_next;
    logic             halt_reg, halt_next;

    logic adv;

    // per-byte decode
    logic [7:0]       b;
    logic             is_last;
    logic             is_digit;
    logic [3:0]       dig;
    logic [34:0]      acc_sum;
    logic             acc_ovf;

    // result being built
    logic [2:0]       r_kind;
    logic [7:0]       r_ch;
    logic [2:0]       r_err;
    logic [1:0]       r_type;
    logic [NUM_W-1:0] r_arg;
    logic             do_flags;
    logic             do_aw;
    logic             do_type;

    // handshake: input register moves on when the result register is free
    assign adv       = s1_valid_reg && (!res_valid_reg || res.ready);
    assign fmt.ready = !s1_valid_reg || adv;

    assign b        = s1_byte_reg;
    assign is_last  = s1_last_reg;
    assign is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
    assign dig      = b[3:0];

    // acc * 10 + digit as (acc << 3) + (acc << 1) + digit
    assign acc_sum = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0}
                   + {31'd0, dig};
    assign acc_ovf = |acc_sum[34:31];

    always_comb
    begin
        phase_next    = phase_reg;
        acc_next      = acc_reg;
        arg_next      = arg_reg;
        width_next    = width_reg;
        prec_next     = prec_reg;
        left_next     = left_reg;
        key_next      = key_reg;
        last_arg_next = last_arg_reg;
        halt_next     = halt_reg;
        r_kind        = K_NONE;
        r_ch          = 8'd0;
        r_err         = E_UNTERM;
        r_type        = T_STR;
        r_arg         = '0;
        do_flags      = 1'b0;
        do_aw         = 1'b0;
        do_type       = 1'b0;

        if (halt_reg)
        begin
            // after an error only the last byte counts
            if (is_last)
            begin
                r_kind = K_END;
            end
        end
        else
        begin
            case (phase_reg)
                PH_PCT:
                begin
                    if (b == CH_PCT)
                    begin
                        r_kind     = K_LIT;
                        r_ch       = b;
                        phase_next = PH_OUT;
                    end
                    else
                    begin
                        arg_next   = '0;
                        width_next = '0;
                        prec_next  = '0;
                        left_next  = 1'b0;
                        key_next   = 1'b0;
                        acc_next   = '0;
                        if (is_digit)
                        begin
                            acc_next   = {27'd0, dig};
                            phase_next = PH_ARGN;
                        end
                        else if (b == CH_LPAREN)
                        begin
                            phase_next = PH_KEY;
                        end
                        else
                        begin
                            do_flags = 1'b1;
                        end
                    end
                end
                PH_ARGN:
                begin
                    if (is_digit)
                    begin
                        if (acc_ovf)
                        begin
                            r_kind     = K_ERR;
                            r_err      = E_RANGE;
                            phase_next = PH_OUT;
                        end
                        else
                        begin
                            acc_next = acc_sum[NUM_W-1:0];
                        end
                    end
                    else if (b == CH_DOLLAR || b == CH_LPAREN)
                    begin
                        if (acc_reg == '0)
                        begin
                            r_kind     = K_ERR;
                            r_err      = E_ZERO;
                            phase_next = PH_OUT;
                        end
                        else
                        begin
                            arg_next   = acc_reg;
                            phase_next = (b == CH_DOLLAR) ? PH_FLAGS : PH_KEY;
                        end
                    end
                    else
                    begin
                        width_next = acc_reg;
                        do_aw      = 1'b1;
                    end
                end
                PH_KEY:
                begin
                    if (b == CH_RPAREN)
                    begin
                        phase_next = PH_FLAGS;
                    end
                    else if (b == CH_LPAREN)
                    begin
                        r_kind     = K_ERR;
                        r_err      = E_PAREN;
                        phase_next = PH_OUT;
                    end
                    else
                    begin
                        r_kind   = K_KEY;
                        r_ch     = b;
                        key_next = 1'b1;
                    end
                end
                PH_FLAGS:
                begin
                    do_flags = 1'b1;
                end
                PH_WIDTH:
                begin
                    if (is_digit)
                    begin
                        if (acc_ovf)
                        begin
                            r_kind     = K_ERR;
                            r_err      = E_RANGE;
                            phase_next = PH_OUT;
                        end
                        else
                        begin
                            acc_next = acc_sum[NUM_W-1:0];
                        end
                    end
                    else
                    begin
                        width_next = acc_reg;
                        do_aw      = 1'b1;
                    end
                end
                PH_DOT:
                begin
                    if (is_digit)
                    begin
                        acc_next   = {27'd0, dig};
                        phase_next = PH_PREC;
                    end
                    else
                    begin
                        r_kind     = K_ERR;
                        r_err      = E_NOPREC;
                        phase_next = PH_OUT;
                    end
                end
                PH_PREC:
                begin
                    if (is_digit)
                    begin
                        if (acc_ovf)
                        begin
                            r_kind     = K_ERR;
                            r_err      = E_RANGE;
                            phase_next = PH_OUT;
                        end
                        else
                        begin
                            acc_next = acc_sum[NUM_W-1:0];
                        end
                    end
                    else
                    begin
                        prec_next = acc_reg;
                        do_type   = 1'b1;
                    end
                end
                default:
                begin
                    // outside a specifier
                    phase_next = PH_OUT;
                    if (b == CH_PCT)
                    begin
                        phase_next = PH_PCT;
                    end
                    else
                    begin
                        r_kind = K_LIT;
                        r_ch   = b;
                    end
                end
            endcase

            // flags, then width start, then dot or type
            if (do_flags)
            begin
                if (b == CH_MINUS)
                begin
                    left_next  = 1'b1;
                    phase_next = PH_FLAGS;
                end
                else if (is_digit)
                begin
                    acc_next   = {27'd0, dig};
                    phase_next = PH_WIDTH;
                end
                else
                begin
                    do_aw = 1'b1;
                end
            end
            if (do_aw)
            begin
                if (b == CH_DOT)
                begin
                    phase_next = PH_DOT;
                end
                else
                begin
                    do_type = 1'b1;
                end
            end
            if (do_type)
            begin
                if (b == CH_S || b == CH_I || b == CH_L)
                begin
                    if (b == CH_S)
                    begin
                        r_type = T_STR;
                    end
                    else if (b == CH_I)
                    begin
                        r_type = T_IDENT;
                    end
                    else
                    begin
                        r_type = T_LIT;
                    end
                    // argument number: explicit, else next implicit one; a keyed spec reuses the last one (1 if none)
                    if (arg_next == '0)
                    begin
                        if (!key_next)
                        begin
                            if (last_arg_reg < NUM_MAX)
                            begin
                                last_arg_next = last_arg_reg + 31'd1;
                            end
                        end
                        else if (last_arg_reg == '0)
                        begin
                            last_arg_next = 31'd1;
                        end
                    end
                    else
                    begin
                        last_arg_next = arg_next;
                    end
                    r_arg      = (arg_next == '0) ? last_arg_next : arg_next;
                    r_kind     = K_SPEC;
                    phase_next = PH_OUT;
                end
                else
                begin
                    r_kind     = K_ERR;
                    r_err      = E_TYPE;
                    phase_next = PH_OUT;
                end
            end

            // string ends inside a specifier
            if (is_last && r_kind != K_ERR && phase_next != PH_OUT)
            begin
                r_kind = K_ERR;
                r_err  = E_UNTERM;
            end
            if (r_kind == K_ERR)
            begin
                halt_next = 1'b1;
            end
        end

        // result fields, zero where the kind does not use them
        res_valid_next           = (r_kind != K_NONE);
        res_next.kind            = r_kind;
        res_next.char_value      = (r_kind == K_LIT || r_kind == K_KEY) ? r_ch : 8'd0;
        res_next.arg_number      = (r_kind == K_SPEC) ? r_arg : '0;
        res_next.has_key         = (r_kind == K_SPEC) && key_next;
        res_next.left_align      = (r_kind == K_SPEC) && left_next;
        res_next.field_width     = (r_kind == K_SPEC) ? width_next : '0;
        res_next.precision_value = (r_kind == K_SPEC) ? prec_next : '0;
        res_next.type_code       = (r_kind == K_SPEC) ? r_type : T_STR;
        res_next.error_code      = (r_kind == K_ERR) ? r_err : E_UNTERM;
        res_next.string_end      = is_last;

        // every string starts from a clean state
        if (is_last)
        begin
            phase_next    = PH_OUT;
            acc_next      = '0;
            arg_next      = '0;
            width_next    = '0;
            prec_next     = '0;
            left_next     = 1'b0;
            key_next      = 1'b0;
            last_arg_next = '0;
            halt_next     = 1'b0;
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (fmt.ready)
        begin
            s1_valid_reg <= fmt.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fmt.valid && fmt.ready)
        begin
            s1_byte_reg <= fmt.format_byte;
            s1_last_reg <= fmt.last_byte;
        end
    end

    // parser state, updated as each byte passes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_OUT;
            acc_reg      <= '0;
            arg_reg      <= '0;
            width_reg    <= '0;
            prec_reg     <= '0;
            left_reg     <= 1'b0;
            key_reg      <= 1'b0;
            last_arg_reg <= '0;
            halt_reg     <= 1'b0;
        end
        else if (adv)
        begin
            phase_reg    <= phase_next;
            acc_reg      <= acc_next;
            arg_reg      <= arg_next;
            width_reg    <= width_next;
            prec_reg     <= prec_next;
            left_reg     <= left_next;
            key_reg      <= key_next;
            last_arg_reg <= last_arg_next;
            halt_reg     <= halt_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            res_valid_reg <= res_valid_next;
        end
        else if (res.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_reg <= res_next;
        end
    end

    assign res.valid           = res_valid_reg;
    assign res.kind            = res_reg.kind;
    assign res.char_value      = res_reg.char_value;
    assign res.arg_number      = res_reg.arg_number;
    assign res.has_key         = res_reg.has_key;
    assign res.left_align      = res_reg.left_align;
    assign res.field_width     = res_reg.field_width;
    assign res.precision_value = res_reg.precision_value;
    assign res.type_code       = res_reg.type_code;
    assign res.error_code      = res_reg.error_code;
    assign res.string_end      = res_reg.string_end;

`ifndef SYNTHESIS
    // an end marker only ever closes a string
    a_end_closes: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_reg.kind == K_END |-> res_reg.string_end)
        else $error("end marker without string end");

    // the last byte leaves the parser in its reset state
    a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
        adv && s1_last_reg |=> phase_reg == PH_OUT && !halt_reg && last_arg_reg == '0)
        else $error("state not cleared after last byte");

    // once halted the parser sits outside any specifier
    a_halt_phase: assert property (@(posedge clk) disable iff (!rst_n)
        halt_reg |-> phase_reg == PH_OUT)
        else $error("halted inside a specifier");

    // a spec record always names an argument
    a_spec_arg: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_reg.kind == K_SPEC |-> res_reg.arg_number != '0)
        else $error("spec record with argument zero");
`endif

endmodule
